@@ rtl/u8u16_pkg.sv @@
// Package for the UTF-8 to UTF-16 transcoder: item types, decoder state,
// constants, the code point splitting function and the error result. No dependencies.
package u8u16_pkg;

    // Depth of the result queue behind the decoder.
    localparam int QueueDepth = 4;

    // Surrogate arithmetic and byte masks.
    localparam logic [15:0] HI_OFFSET = 16'hD7C0;
    localparam logic [15:0] LO_BASE   = 16'hDC00;
    localparam logic [20:0] PAIR_MIN  = 21'h10000;
    localparam logic [1:0]  CONT_TAG  = 2'b10;

    // One input item: a byte of UTF-8 text.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } u8u16_in_t;

    // One result item: a UTF-16 code unit with its flags.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_last;
        logic        string_done;
        logic        bad_input;
    } u8u16_out_t;

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        logic [1:0]  bytes_pending;
        logic [20:0] code_accum;
        logic        discarding;
    } u8u16_state_t;

    // Results caused by one byte, handed from the decoder to the queue.
    typedef struct packed {
        logic [1:0] count;
        u8u16_out_t first;
        u8u16_out_t second;
    } u8u16_push_t;

    // Turns a finished code point into one unit or a surrogate pair.
    function automatic u8u16_push_t emit_cp(logic [20:0] cp, logic fin);
        u8u16_push_t p;
        p = '0;
        if (cp < PAIR_MIN)
        begin
            p.count = 2'd1;
            p.first = '{code_unit: cp[15:0], run_last: 1'b1,
                        string_done: fin, bad_input: 1'b0};
        end
        else
        begin
            p.count = 2'd2;
            p.first = '{code_unit: {5'd0, cp[20:10]} + HI_OFFSET, run_last: 1'b0,
                        string_done: 1'b0, bad_input: 1'b0};
            p.second = '{code_unit: {6'd0, cp[9:0]} + LO_BASE, run_last: 1'b1,
                         string_done: fin, bad_input: 1'b0};
        end
        return p;
    endfunction

    // The single error result that ends a malformed string.
    function automatic u8u16_push_t error_result();
        u8u16_push_t p;
        p = '0;
        p.count = 2'd1;
        p.first = '{code_unit: 16'd0, run_last: 1'b1,
                    string_done: 1'b1, bad_input: 1'b1};
        return p;
    endfunction

endpackage

@@ rtl/u8u16_decode.sv @@
// Byte decoder: holds the sequence state and turns each byte into results.
// Depends on u8u16_pkg.
module u8u16_decode
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        enable,
    input  u8u16_in_t   item,
    output u8u16_push_t push
);

    u8u16_state_t st_reg;
    u8u16_state_t st_next;
    logic [7:0]   b;
    logic         fin;
    logic [20:0]  acc_shift;

    assign b         = item.in_byte;
    assign fin       = item.text_end;
    assign acc_shift = {st_reg.code_accum[14:0], b[5:0]};

    // Decode one byte against the current state.
    always_comb
    begin
        st_next = st_reg;
        push    = '0;
        if (st_reg.discarding)
        begin
            // Bytes of a bad string are dropped until its end.
            if (fin)
            begin
                st_next.discarding = 1'b0;
            end
        end
        else if (st_reg.bytes_pending == 2'd0)
        begin
            if (!b[7])
            begin
                push = emit_cp({13'd0, b}, fin);
            end
            else if (!b[6] || (b[5] && b[4] && b[3]) || fin)
            begin
                // Stray continuation, oversized lead or a lead cut off.
                push    = error_result();
                st_next = '{bytes_pending: 2'd0, code_accum: '0, discarding: !fin};
            end
            else if (!b[5])
            begin
                st_next.code_accum    = {16'd0, b[4:0]};
                st_next.bytes_pending = 2'd1;
            end
            else if (!b[4])
            begin
                st_next.code_accum    = {17'd0, b[3:0]};
                st_next.bytes_pending = 2'd2;
            end
            else
            begin
                st_next.code_accum    = {18'd0, b[2:0]};
                st_next.bytes_pending = 2'd3;
            end
        end
        else if (b[7:6] != CONT_TAG)
        begin
            // A continuation byte was expected.
            push    = error_result();
            st_next = '{bytes_pending: 2'd0, code_accum: '0, discarding: !fin};
        end
        else if (st_reg.bytes_pending == 2'd1)
        begin
            push                  = emit_cp(acc_shift, fin);
            st_next.code_accum    = '0;
            st_next.bytes_pending = 2'd0;
        end
        else if (fin)
        begin
            // The string ends in the middle of a sequence.
            push    = error_result();
            st_next = '{bytes_pending: 2'd0, code_accum: '0, discarding: 1'b0};
        end
        else
        begin
            st_next.code_accum    = acc_shift;
            st_next.bytes_pending = st_reg.bytes_pending - 2'd1;
        end
    end

    // State advances only when the byte is actually processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (enable)
        begin
            st_reg <= st_next;
        end
    end

endmodule

@@ rtl/u8u16_fifo.sv @@
// Result queue: takes up to two result items a cycle and hands out one unless stalled.
// Depends on u8u16_pkg.
module u8u16_fifo
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_en,
    input  u8u16_push_t push,
    output logic        room,
    output logic        valid,
    input  logic        stall,
    output u8u16_out_t  item
);

    localparam int PtrW = $clog2(QueueDepth);
    localparam int CntW = $clog2(QueueDepth + 1);

    u8u16_out_t          mem [QueueDepth];
    logic [PtrW-1:0]     rd_ptr_reg;
    logic [PtrW-1:0]     rd_ptr_next;
    logic [PtrW-1:0]     wr_ptr_reg;
    logic [PtrW-1:0]     wr_ptr_next;
    logic [PtrW-1:0]     wr_ptr_plus;
    logic [CntW-1:0]     count_reg;
    logic [CntW-1:0]     count_next;
    logic [1:0]          n_push;
    logic                pop;

    assign n_push      = push_en ? push.count : 2'd0;
    assign pop         = valid && !stall;
    assign valid       = (count_reg != '0);
    assign item        = mem[rd_ptr_reg];
    assign room        = (count_reg <= CntW'(QueueDepth - 2));
    assign wr_ptr_plus = wr_ptr_reg + PtrW'(1);

    // Pointer and fill count bookkeeping.
    always_comb
    begin
        rd_ptr_next = pop ? rd_ptr_reg + PtrW'(1) : rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg + PtrW'(n_push);
        count_next  = count_reg + CntW'(n_push) - CntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage for waiting result items.
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (n_push == 2'd2)
        begin
            mem[wr_ptr_plus] <= push.second;
        end
    end

endmodule

@@ rtl/utf8_to_utf16_transcoder_top.sv @@
// UTF-8 to UTF-16 transcoder, top level.
// A byte is held in the input register, then decoded into the result queue that offers its results.
// Throughput: one byte a cycle; the input stalls only while the receiver holds off and the
// result queue backs up, as a surrogate pair needs four bytes for its two result items.
// Reset clears the input register's valid flag, the decoder state and the result queue.
// Depends on u8u16_pkg, u8u16_decode and u8u16_fifo.
module utf8_to_utf16_transcoder_top
    import u8u16_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  u8u16_in_t  byte_item,
    output logic       unit_valid,
    input  logic       unit_stall,
    output u8u16_out_t unit_item
);

    logic        hold_valid_reg;
    logic        hold_valid_next;
    u8u16_in_t   hold_item_reg;
    logic        room;
    logic        fire;
    logic        take;
    u8u16_push_t push;

    // A held byte is processed once the queue has space for two results.
    assign fire       = hold_valid_reg && room;
    assign byte_stall = hold_valid_reg && !room;
    assign take       = byte_valid && !byte_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (fire)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_item_reg <= byte_item;
        end
    end

    u8u16_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .enable (fire),
        .item   (hold_item_reg),
        .push   (push)
    );

    u8u16_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_en (fire),
        .push    (push),
        .room    (room),
        .valid   (unit_valid),
        .stall   (unit_stall),
        .item    (unit_item)
    );

endmodule

@@ bench/tb_utf8_to_utf16_transcoder_top.sv @@
// Self-checking bench for the UTF-8 to UTF-16 transcoder: directed bytes, then random strings,
// each result item checked against fixed row results or a byte-level decoder fed the accepted bytes.
// Depends on u8u16_pkg and utf8_to_utf16_transcoder_top.
`timescale 1ns / 100ps

module tb_utf8_to_utf16_transcoder_top;
    import u8u16_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_TARGET = 1925;
    localparam int LONG_HOLD     = 150;
    localparam int DRAIN_CYCLES  = 8;

    localparam logic [20:0] PAIR_START = 21'h10000;
    localparam logic [15:0] HIGH_BIAS  = 16'hD7C0;
    localparam logic [15:0] LOW_BIAS   = 16'hDC00;
    localparam logic [1:0]  CONT_MARK  = 2'b10;

    localparam u8u16_out_t NO_UNIT  = '0;
    localparam u8u16_out_t BAD_UNIT = '{16'h0000, 1'b1, 1'b1, 1'b1};

    // One byte of stimulus; where fixed is set, the listed results are taken as written.
    typedef struct packed {
        u8u16_in_t  text_byte;
        logic       fixed;
        logic [1:0] fixed_count;
        u8u16_out_t unit0;
        u8u16_out_t unit1;
    } text_row_t;

    // Directed bytes: plain ASCII, each sequence length, a surrogate pair, stray
    // continuation, an oversized lead, bad continuation, cut-off sequences and the largest
    // code point the lax decoder accepts.
    localparam text_row_t DIRECTED_ROWS [25] = '{
        '{'{8'h00, 1'b0}, 1'b1, 2'd1, '{16'h0000, 1'b1, 1'b0, 1'b0}, NO_UNIT},
        '{'{8'h7F, 1'b1}, 1'b1, 2'd1, '{16'h007F, 1'b1, 1'b1, 1'b0}, NO_UNIT},
        '{'{8'hC3, 1'b0}, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
        '{'{8'hA9, 1'b1}, 1'b1, 2'd1, '{16'h00E9, 1'b1, 1'b1, 1'b0}, NO_UNIT},
        '{'{8'hE2, 1'b0}, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
        '{'{8'h82, 1'b0}, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
        '{'{8'hAC, 1'b0}, 1'b1, 2'd1, '{16'h20AC, 1'b1, 1'b0, 1'b0}, NO_UNIT},
        '{'{8'hF0, 1'b0}, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
        '{'{8'h9F, 1'b0}, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
        '{'{8'h98, 1'b0}, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
        '{'{8'h80, 1'b1}, 1'b1, 2'd2, '{16'hD83D, 1'b0, 1'b0, 1'b0},
          '{16'hDE00, 1'b1, 1'b1, 1'b0}},
        '{'{8'h80, 1'b0}, 1'b1, 2'd1, BAD_UNIT, NO_UNIT},
        '{'{8'h41, 1'b0}, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
        '{'{8'hFF, 1'b1}, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
        '{'{8'hF8, 1'b1}, 1'b1, 2'd1, BAD_UNIT, NO_UNIT},
        '{'{8'hE0, 1'b1}, 1'b1, 2'd1, BAD_UNIT, NO_UNIT},
        '{'{8'hE1, 1'b0}, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
        '{'{8'h41, 1'b0}, 1'b1, 2'd1, BAD_UNIT, NO_UNIT},
        '{'{8'h00, 1'b1}, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
        '{'{8'hF7, 1'b0}, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
        '{'{8'hBF, 1'b0}, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
        '{'{8'hBF, 1'b0}, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
        '{'{8'hBF, 1'b1}, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
        '{'{8'hF4, 1'b0}, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
        '{'{8'h8F, 1'b1}, 1'b0, 2'd0, NO_UNIT, NO_UNIT}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    u8u16_in_t  byte_item = '0;
    logic       unit_valid;
    logic       unit_stall = 1'b1;
    u8u16_out_t unit_item;

    // Decoder state mirrored from accepted bytes.
    logic [1:0]  dec_pending = '0;
    logic [20:0] dec_accum = '0;
    logic        dec_discard = 1'b0;

    text_row_t  text_rows[$];
    u8u16_out_t pending_units[$];
    int         mismatch_count = 0;
    int         units_seen = 0;
    int         cycle_count = 0;

    utf8_to_utf16_transcoder_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .unit_item  (unit_item)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Turns a finished code point into one unit or a surrogate pair.
    function automatic int split_code_point(input logic [20:0] cp, input logic fin,
                                            output u8u16_out_t u0, output u8u16_out_t u1);
        logic [15:0] high_half;
        logic [15:0] low_half;
        u0 = NO_UNIT;
        u1 = NO_UNIT;
        if (cp < PAIR_START)
        begin
            u0 = '{cp[15:0], 1'b1, fin, 1'b0};
            return 1;
        end
        high_half = 16'(cp[20:10]) + HIGH_BIAS;
        low_half  = 16'(cp[9:0]) + LOW_BIAS;
        u0 = '{high_half, 1'b0, 1'b0, 1'b0};
        u1 = '{low_half, 1'b1, fin, 1'b0};
        return 2;
    endfunction

    // Ends a malformed string with the error item; the rest of it is dropped.
    function automatic int abandon_text(input logic fin, output u8u16_out_t u0);
        dec_pending = '0;
        dec_accum   = '0;
        dec_discard = !fin;
        u0 = BAD_UNIT;
        return 1;
    endfunction

    // Decodes one accepted byte and returns how many result items it causes.
    function automatic int decode_utf8_byte(input u8u16_in_t b,
                                            output u8u16_out_t u0, output u8u16_out_t u1);
        int          ones;
        logic [20:0] cp;
        u0 = NO_UNIT;
        u1 = NO_UNIT;
        if (dec_discard)
        begin
            if (b.text_end)
                dec_discard = 1'b0;
            return 0;
        end

        // Expecting a lead byte: its leading ones give the sequence length.
        if (dec_pending == 2'd0)
        begin
            casez (b.in_byte)
                8'b0???????: ones = 0;
                8'b10??????: ones = 1;
                8'b110?????: ones = 2;
                8'b1110????: ones = 3;
                8'b11110???: ones = 4;
                default:     ones = 5;
            endcase
            if (ones == 0)
                return split_code_point({13'd0, b.in_byte}, b.text_end, u0, u1);
            if (ones == 1 || ones > 4 || b.text_end)
                return abandon_text(b.text_end, u0);
            case (ones)
                2:       dec_accum = {16'd0, b.in_byte[4:0]};
                3:       dec_accum = {17'd0, b.in_byte[3:0]};
                default: dec_accum = {18'd0, b.in_byte[2:0]};
            endcase
            dec_pending = 2'(ones - 1);
            return 0;
        end

        // Expecting a continuation byte.
        if (b.in_byte[7:6] != CONT_MARK)
            return abandon_text(b.text_end, u0);
        dec_accum   = {dec_accum[14:0], b.in_byte[5:0]};
        dec_pending = dec_pending - 2'd1;
        if (dec_pending == 2'd0)
        begin
            cp = dec_accum;
            dec_accum = '0;
            return split_code_point(cp, b.text_end, u0, u1);
        end
        if (b.text_end)
            return abandon_text(b.text_end, u0);
        return 0;
    endfunction

    // Appends one random string: mostly well-formed UTF-8, sometimes corrupted, cut short,
    // given a stray continuation byte, or replaced by raw noise.
    task automatic append_random_text();
        u8u16_in_t  text[$];
        int         pick;
        int         n_cp;
        int         len;
        logic [7:0] lead;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            repeat ($urandom_range(1, 6))
                text.push_back(u8u16_in_t'($urandom));
        end
        else
        begin
            n_cp = $urandom_range(1, 8);
            repeat (n_cp)
            begin
                len = $urandom_range(1, 4);
                case (len)
                    1:       lead = 8'($urandom_range(0, 127));
                    2:       lead = {3'b110, 5'($urandom)};
                    3:       lead = {4'b1110, 4'($urandom)};
                    default: lead = {5'b11110, 3'($urandom)};
                endcase
                text.push_back('{lead, 1'b0});
                repeat (len - 1)
                    text.push_back('{{CONT_MARK, 6'($urandom)}, 1'b0});
            end
            if (pick < 22)
                text[$urandom_range(0, text.size() - 1)].in_byte = 8'($urandom);
            else if (pick < 30)
            begin
                repeat ($urandom_range(0, text.size() - 1))
                    void'(text.pop_back());
            end
            else if (pick < 35)
                text.insert($urandom_range(0, text.size()), '{{CONT_MARK, 6'($urandom)}, 1'b0});
        end
        text[text.size() - 1].text_end = 1'b1;
        foreach (text[i])
            text_rows.push_back('{text[i], 1'b0, 2'd0, NO_UNIT, NO_UNIT});
    endtask

    task automatic report_mismatch(input string what, input u8u16_out_t want,
                                   input u8u16_out_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s at unit %0d: expected %h/%b/%b/%b, got %h/%b/%b/%b", what, units_seen,
                     want.code_unit, want.run_last, want.string_done, want.bad_input,
                     got.code_unit, got.run_last, got.string_done, got.bad_input);
    endtask

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random stalls, bursts with none, and one long hold-off that backs up
    // the block; every accepted item is checked against the oldest expectation.
    initial
    begin : unit_sink
        int         wait_cycles;
        bit         long_hold_done;
        u8u16_out_t want;
        long_hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            wait_cycles = $urandom_range(0, 3);
            if ((units_seen / 120) % 4 == 2)
                wait_cycles = 0;
            if (units_seen == 400 && !long_hold_done)
            begin
                wait_cycles = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (wait_cycles > 0)
            begin
                unit_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            unit_stall <= 1'b0;
            @(posedge clk);
            while (unit_valid !== 1'b1)
                @(posedge clk);
            if (pending_units.size() == 0)
                report_mismatch("unexpected item", NO_UNIT, unit_item);
            else
            begin
                want = pending_units.pop_front();
                if (unit_item.code_unit !== want.code_unit
                    || unit_item.run_last !== want.run_last
                    || unit_item.string_done !== want.string_done
                    || unit_item.bad_input !== want.bad_input)
                    report_mismatch("mismatch", want, unit_item);
            end
            units_seen++;
        end
    end

    // Byte side: reset, then the directed table followed by random text.
    initial
    begin : byte_source
        int         gap;
        int         n;
        text_row_t  row;
        u8u16_out_t u0;
        u8u16_out_t u1;
        foreach (DIRECTED_ROWS[i])
            text_rows.push_back(DIRECTED_ROWS[i]);
        while (text_rows.size() < RANDOM_TARGET)
            append_random_text();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (text_rows[idx])
        begin
            row = text_rows[idx];
            gap = $urandom_range(0, 3);
            if ((idx / 150) % 4 == 3)
                gap = 0;
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            byte_valid <= 1'b1;
            byte_item  <= row.text_byte;
            @(posedge clk);
            while (byte_stall !== 1'b0)
                @(posedge clk);

            // Accepted at this edge.
            n = decode_utf8_byte(row.text_byte, u0, u1);
            if (row.fixed)
            begin
                n  = row.fixed_count;
                u0 = row.unit0;
                u1 = row.unit1;
            end
            if (n > 0)
                pending_units.push_back(u0);
            if (n > 1)
                pending_units.push_back(u1);
        end
        byte_valid <= 1'b0;

        while (pending_units.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
